/* rtl/bisl_pkg.sv */
package bisl_pkg;

  localparam int unsigned LimitWidth = 21;
  localparam logic [LimitWidth-1:0] LimitReset = 21'd16384;

  localparam logic [7:0] SigByte0 = 8'h43;
  localparam logic [7:0] SigByte1 = 8'h59;

  localparam logic [31:0] AddrStep = 32'd4;

  // parse phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_JUMP  = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_BAD_SIG  = 3'd2;
  localparam logic [2:0] KIND_TOO_LONG = 3'd3;
  localparam logic [2:0] KIND_MISMATCH = 3'd4;

  typedef struct packed {
    logic [31:0] image_word;
    logic        start_of_image;
  } bisl_in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] target_address;
    logic [31:0] write_data;
  } bisl_out_t;

endpackage

/* rtl/boot_image_stream_loader_top.sv */
// a beat taken at the input gives its result beat through the input register,
// then parse logic into the output register
// throughput: one beat per cycle; only a stalled output slows the input
// reset (rst_n, synchronous): parser idle waiting for a start word, sum,
// address, count and jump address cleared, segment limit back to 16384 words
module boot_image_stream_loader_top import bisl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: segment length limit
  input  logic                  cfg_wr_en,
  input  logic [LimitWidth-1:0] cfg_wr_data,
  // image word beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bisl_in_t              in_item,
  // ram write / status beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output bisl_out_t             out_item
);

  logic [LimitWidth-1:0] limit_r;
  logic                  hold_valid_r, hold_valid_nxt;
  bisl_in_t              hold_item_r;
  logic                  out_valid_r, out_valid_nxt;
  bisl_out_t             out_item_r;
  logic                  out_free;
  logic                  step;
  logic                  in_take;
  logic                  res_valid;
  bisl_out_t             res;

  // output register can load when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  // held word is parsed when its result (if any) has a place to go
  assign step     = hold_valid_r && out_free;
  // input register frees up as soon as its word is parsed
  assign in_stall = hold_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_take) begin
      hold_valid_nxt = 1'b1;
    end else if (step) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = step && res_valid;
    end
  end

  // limit register keeps only the low bits by port width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LimitReset;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_item_r <= in_item;
    end
    if (step && res_valid && out_free) begin
      out_item_r <= res;
    end
  end

  // signature check, segment walk, checksum compare
  bisl_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (hold_item_r),
    .limit     (limit_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/bisl_parse.sv */
module bisl_parse import bisl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  bisl_in_t              item,
  input  logic [LimitWidth-1:0] limit,
  output logic                  res_valid,
  output bisl_out_t             res
);

  logic [2:0]            phase_r, phase_nxt;
  logic [LimitWidth-1:0] left_r, left_nxt;
  logic [31:0]           addr_r, addr_nxt;
  logic [31:0]           sum_r, sum_nxt;
  logic [31:0]           jump_r, jump_nxt;
  logic [LimitWidth-1:0] left_dec;
  logic                  sig_ok;
  logic                  too_long;

  assign sig_ok   = (item.image_word[7:0] == SigByte0) && (item.image_word[15:8] == SigByte1);
  assign too_long = item.image_word > {{(32-LimitWidth){1'b0}}, limit};
  assign left_dec = left_r - {{(LimitWidth-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    addr_nxt  = addr_r;
    sum_nxt   = sum_r;
    jump_nxt  = jump_r;
    res_valid = 1'b0;
    res       = '0;
    if (item.start_of_image) begin
      sum_nxt  = '0;
      left_nxt = '0;
      if (sig_ok) begin
        phase_nxt = PH_COUNT;
      end else begin
        phase_nxt       = PH_IDLE;
        res_valid       = 1'b1;
        res.result_kind = KIND_BAD_SIG;
      end
    end else begin
      unique case (phase_r)
        PH_COUNT: begin
          if (item.image_word == '0) begin
            phase_nxt = PH_JUMP;
          end else if (too_long) begin
            phase_nxt       = PH_IDLE;
            res_valid       = 1'b1;
            res.result_kind = KIND_TOO_LONG;
          end else begin
            left_nxt  = item.image_word[LimitWidth-1:0];
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR: begin
          addr_nxt  = item.image_word;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          sum_nxt  = sum_r + item.image_word;
          addr_nxt = addr_r + AddrStep;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_COUNT;
          end
          res_valid          = 1'b1;
          res.result_kind    = KIND_WRITE;
          res.target_address = addr_r;
          res.write_data     = item.image_word;
        end
        PH_JUMP: begin
          jump_nxt  = item.image_word;
          phase_nxt = PH_CHECK;
        end
        PH_CHECK: begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
          if (item.image_word == sum_r) begin
            res.result_kind    = KIND_GOOD;
            res.target_address = jump_r;
          end else begin
            res.result_kind = KIND_MISMATCH;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      left_r  <= '0;
      addr_r  <= '0;
      sum_r   <= '0;
      jump_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      addr_r  <= addr_nxt;
      sum_r   <= sum_nxt;
      jump_r  <= jump_nxt;
    end
  end

endmodule

/* tb/boot_image_stream_loader_top_tb.sv */
module boot_image_stream_loader_top_tb import bisl_pkg::*;;

  // predicts the ram write / status beats of the loader and checks them in order
  class loader_scoreboard;
    logic [LimitWidth-1:0] limit      = LimitReset;
    logic [2:0]            phase      = PH_IDLE;
    logic [LimitWidth-1:0] words_left = '0;
    logic [31:0]           load_addr  = '0;
    logic [31:0]           word_sum   = '0;
    logic [31:0]           jump_addr  = '0;
    bisl_out_t             due_beats[$];
    int unsigned           fails      = 0;

    function void queue_beat(logic [2:0] kind, logic [31:0] addr, logic [31:0] data);
      bisl_out_t b;
      b.result_kind    = kind;
      b.target_address = addr;
      b.write_data     = data;
      due_beats.push_back(b);
    endfunction

    // one accepted image word
    function void note_word(bisl_in_t b);
      logic [31:0] w;
      w = b.image_word;
      if (b.start_of_image) begin
        word_sum   = '0;
        words_left = '0;
        if (w[7:0] == SigByte0 && w[15:8] == SigByte1) begin
          phase = PH_COUNT;
        end else begin
          phase = PH_IDLE;
          queue_beat(KIND_BAD_SIG, '0, '0);
        end
      end else begin
        case (phase)
          PH_COUNT: begin
            if (w == '0) begin
              phase = PH_JUMP;
            end else if (w > 32'(limit)) begin
              phase = PH_IDLE;
              queue_beat(KIND_TOO_LONG, '0, '0);
            end else begin
              words_left = w[LimitWidth-1:0];
              phase      = PH_ADDR;
            end
          end
          PH_ADDR: begin
            load_addr = w;
            phase     = PH_DATA;
          end
          PH_DATA: begin
            queue_beat(KIND_WRITE, load_addr, w);
            word_sum   = word_sum + w;
            load_addr  = load_addr + AddrStep;
            words_left = words_left - 1'b1;
            if (words_left == '0) phase = PH_COUNT;
          end
          PH_JUMP: begin
            jump_addr = w;
            phase     = PH_CHECK;
          end
          PH_CHECK: begin
            phase = PH_IDLE;
            if (w == word_sum) queue_beat(KIND_GOOD, jump_addr, '0);
            else queue_beat(KIND_MISMATCH, '0, '0);
          end
          default: phase = PH_IDLE;
        endcase
      end
    endfunction

    function void check_beat(bisl_out_t got);
      bisl_out_t want;
      if (due_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d addr %h data %h",
               got.result_kind, got.target_address, got.write_data);
        fails++;
      end else begin
        want = due_beats.pop_front();
        if (got.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
          fails++;
        end
        if (got.target_address !== want.target_address) begin
          $error("target_address: expected %h, actual %h",
                 want.target_address, got.target_address);
          fails++;
        end
        if (got.write_data !== want.write_data) begin
          $error("write_data: expected %h, actual %h", want.write_data, got.write_data);
          fails++;
        end
      end
    endfunction
  endclass

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned PhaseBeats = 155;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [LimitWidth-1:0] cfg_wr_data;
  logic                  in_valid;
  logic                  in_stall;
  bisl_in_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  bisl_out_t             out_item;

  loader_scoreboard tracker = new;

  // segment limit as the stimulus side sees it
  logic [LimitWidth-1:0] cur_limit = LimitReset;
  // idling switches, redrawn per image so that quiet stretches occur
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  // asks the receiving side for one long hold-off
  bit          hold_req     = 1'b0;
  int unsigned beats_sent   = 0;
  int unsigned quiet_cycles = 0;

  boot_image_stream_loader_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bisl_in_t word_beat(logic [31:0] w, logic s);
    bisl_in_t b;
    b.image_word     = w;
    b.start_of_image = s;
    return b;
  endfunction

  // offer one beat after a random gap, return at the edge that takes it
  task automatic send_beat(input bisl_in_t b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = b;
    do @(posedge clk); while (in_stall);
    tracker.note_word(b);
    beats_sent++;
  endtask

  // drop valid, let every expected beat arrive, then cover the pipeline latency
  // so that words with no result have also passed through
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.due_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LimitWidth-1:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tracker.limit = v;
    cur_limit     = v;
  endtask

  // one image with random content; most are well formed, the rest are broken
  // in one way: bad checksum, cut off by a restart, oversized segment count,
  // bad signature, or plain noise
  task automatic stream_image(input bit long_burst);
    bisl_in_t    img[$];
    int unsigned flavor;
    int unsigned mode;
    int unsigned nseg;
    int unsigned cnt;
    int unsigned ndata;
    int unsigned keep;
    logic [31:0] sum;
    logic [31:0] w;
    bit          cut;
    flavor     = long_burst ? 0 : $urandom_range(0, 99);
    mode       = long_burst ? 2 : $urandom_range(0, 3);
    tx_idle_on = (mode & 1) != 0;
    rx_idle_on = (mode & 2) != 0;
    sum = '0;
    cut = 1'b0;

    w = $urandom;
    w[7:0]  = SigByte0;
    w[15:8] = SigByte1;
    img.push_back(word_beat(w, 1'b1));

    nseg = (cur_limit == 0) ? 0 : (long_burst ? 1 : $urandom_range(0, 4));
    for (int unsigned s = 0; s < nseg && !cut; s++) begin
      cnt = $urandom_range(1, (cur_limit < 6) ? cur_limit : 6);
      // segment exactly at the limit
      if (cur_limit <= 64 && $urandom_range(0, 7) == 0) cnt = 32'(cur_limit);
      if (long_burst) cnt = 48;
      ndata = cnt;
      if (flavor >= 70 && flavor < 78 && s == 0 && $urandom_range(0, 1) == 1) begin
        // longest legal segment, abandoned after a few words by the next start
        cnt   = 32'(cur_limit);
        ndata = $urandom_range(0, 3);
        cut   = 1'b1;
      end
      img.push_back(word_beat(cnt, 1'b0));
      img.push_back(word_beat($urandom, 1'b0));
      for (int unsigned k = 0; k < ndata; k++) begin
        w   = $urandom;
        sum = sum + w;
        img.push_back(word_beat(w, 1'b0));
      end
    end

    if (!cut) begin
      if (flavor >= 78 && flavor < 86) begin
        case ($urandom_range(0, 3))
          0:       w = cur_limit + 1;
          1:       w = cur_limit + $urandom_range(1, 1000);
          2:       w = $urandom | 32'h8000_0000;
          default: w = 32'hFFFF_FFFF;
        endcase
        img.push_back(word_beat(w, 1'b0));
        // words after the error land while idle
        repeat ($urandom_range(0, 2)) img.push_back(word_beat($urandom, 1'b0));
      end else begin
        img.push_back(word_beat('0, 1'b0));
        img.push_back(word_beat($urandom, 1'b0));
        if (flavor >= 60 && flavor < 70) begin
          img.push_back(word_beat(sum ^ $urandom_range(1, 32'hFFFF_FFFF), 1'b0));
        end else begin
          img.push_back(word_beat(sum, 1'b0));
        end
      end
      // restart at a random point of the parse
      if (flavor >= 70 && flavor < 78) begin
        keep = $urandom_range(1, img.size() - 1);
        while (img.size() > keep) void'(img.pop_back());
      end
    end

    if (flavor >= 86 && flavor < 92) begin
      w = img[0].image_word;
      case ($urandom_range(0, 2))
        0:       w[7:0]  = w[7:0] ^ 8'($urandom_range(1, 255));
        1:       w[15:8] = w[15:8] ^ 8'($urandom_range(1, 255));
        default: w[15:0] = w[15:0] ^ 16'($urandom_range(1, 16'hFFFF));
      endcase
      img[0].image_word = w;
    end else if (flavor >= 92) begin
      img.delete();
      repeat ($urandom_range(1, 6)) begin
        img.push_back(word_beat($urandom, $urandom_range(0, 7) == 0));
      end
    end

    foreach (img[i]) send_beat(img[i]);
  endtask

  // receiving side: random hold-off before each result beat, one long hold on request
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (hold_req) begin
        hold     = LongHold;
        hold_req = 1'b0;
      end
      if (hold != 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checking and the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_beat(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [LimitWidth-1:0] limits [7];
    int unsigned           target;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_item     = '0;
    limits = '{21'd0, 21'd1, 21'h1F_FFFF, 21'd1048576, 21'd5, 21'd3, 21'd0};
    limits[6] = $urandom_range(1, 64);
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed part under the reset limit
    // word before any start is dropped
    send_beat(word_beat(32'hFFFF_FFFF, 1'b0));
    // all-zero start word: bad signature
    send_beat(word_beat(32'h0000_0000, 1'b1));
    send_beat(word_beat({16'hFFFF, SigByte1, SigByte0}, 1'b1));
    // two words at the top of the address space, address wraps
    send_beat(word_beat(32'd2, 1'b0));
    send_beat(word_beat(32'hFFFF_FFF8, 1'b0));
    send_beat(word_beat(32'hFFFF_FFFF, 1'b0));
    send_beat(word_beat(32'h0000_0001, 1'b0));
    send_beat(word_beat(32'd1, 1'b0));
    send_beat(word_beat(32'hFFFF_FFFC, 1'b0));
    send_beat(word_beat(32'h8000_0000, 1'b0));
    send_beat(word_beat(32'd0, 1'b0));
    send_beat(word_beat(32'h1234_5678, 1'b0));
    // sum wrapped to 0x8000_0000: good image
    send_beat(word_beat(32'h8000_0000, 1'b0));
    // one above the limit
    send_beat(word_beat({16'h0000, SigByte1, SigByte0}, 1'b1));
    send_beat(word_beat(32'(LimitReset) + 1, 1'b0));
    // exactly at the limit, then a restart in the middle of the data
    send_beat(word_beat({16'hA5A5, SigByte1, SigByte0}, 1'b1));
    send_beat(word_beat(32'(LimitReset), 1'b0));
    send_beat(word_beat(32'h0000_0000, 1'b0));
    send_beat(word_beat(32'hA5A5_A5A5, 1'b0));
    // empty image with a wrong checksum
    send_beat(word_beat({16'h5A5A, SigByte1, SigByte0}, 1'b1));
    send_beat(word_beat(32'd0, 1'b0));
    send_beat(word_beat(32'd0, 1'b0));
    send_beat(word_beat(32'hFFFF_FFFF, 1'b0));
    // each signature byte wrong on its own
    send_beat(word_beat({16'hFFFF, SigByte1, ~SigByte0}, 1'b1));
    send_beat(word_beat({16'h0000, SigByte0, SigByte0}, 1'b1));

    // random images under a series of limits, zero and the field maximum among them
    foreach (limits[p]) begin
      settle();
      write_limit(limits[p]);
      target = beats_sent + PhaseBeats;
      if (limits[p] == 21'h1F_FFFF) begin
        // long receiver hold-off while a long segment streams in back to back
        hold_req = 1'b1;
        stream_image(1'b1);
      end
      while (beats_sent < target) stream_image(1'b0);
    end

    settle();
    if (tracker.fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/bisl_pkg.sv
rtl/bisl_parse.sv
rtl/boot_image_stream_loader_top.sv
tb/boot_image_stream_loader_top_tb.sv
